// ===== src/eded_pkg.sv =====
// shared types and constants for the edit distance engine
// no dependencies; imported by every module of the block

package eded_pkg;

  localparam int MAX_LEN_DEF = 32;
  localparam int SYM_W       = 8;
  localparam int CMD_W       = 2;
  localparam int DIST_W      = 6;
  localparam int DIST_MAX    = 63;

  typedef enum logic [CMD_W-1:0] {
    CMD_RESET = 2'd0,
    CMD_REF   = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_BUSY = 2'b10
  } state_t;

endpackage

// ===== src/edit_distance_engine_core.sv =====
// levenshtein edit distance engine: a row of MAX_LEN column cells, a query word sweeps it
// timing: reset, reference append and error words give their result in the cycle after acceptance;
//   a query word gives its result once the wave has crossed every active cell
// throughput: one word at a time, set by the wave crossing one cell per cycle
// reset: synchronous active-low rst_n empties both strings, column entry k holds k
// depends on eded_pkg and eded_cell

module edit_distance_engine_core import eded_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CMD_W-1:0]  in_command,
  input  logic [SYM_W-1:0]  in_symbol,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DIST_W-1:0] out_distance,
  output logic              out_error
);

  // lengths and distances run 0..MAX_LEN
  localparam int LW = $clog2(MAX_LEN + 1);

  state_t          state_r, state_nxt;
  logic [LW-1:0]   ref_len_r, ref_len_nxt;
  logic [LW-1:0]   qlen_r, qlen_nxt;
  logic [LW-1:0]   cur_r, cur_nxt;
  logic            out_vld_r, out_vld_nxt;
  logic            err_r, err_nxt;

  logic            accept;
  cmd_t            cmd;
  logic            clear;
  logic            ref_wr;
  logic            wave_start;

  // wave taps between neighboring cells, entry 0 feeds the first cell
  logic             wv_vld  [MAX_LEN+1];
  logic [SYM_W-1:0] wv_sym  [MAX_LEN+1];
  logic [LW-1:0]    wv_diag [MAX_LEN+1];
  logic [LW-1:0]    wv_left [MAX_LEN+1];

  logic            wave_done;
  logic [LW-1:0]   wave_dist;
  logic [DIST_W+LW-1:0] cur_ext;

  assign cmd    = cmd_t'(in_command);
  assign accept = in_valid && in_ready;

  // new word only when idle and the result slot is free or being emptied
  assign in_ready = (state_r == ST_IDLE) && (!out_vld_r || out_ready);

  // result of the last active cell closes the sweep
  assign wave_done = wv_vld[ref_len_r];
  assign wave_dist = wv_left[ref_len_r];

  always_comb begin
    state_nxt   = state_r;
    ref_len_nxt = ref_len_r;
    qlen_nxt    = qlen_r;
    cur_nxt     = cur_r;
    out_vld_nxt = out_vld_r;
    err_nxt     = err_r;
    clear       = 1'b0;
    ref_wr      = 1'b0;
    wave_start  = 1'b0;

    if (out_vld_r && out_ready) begin
      out_vld_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_vld_nxt = 1'b1;
          err_nxt     = 1'b0;
          case (cmd)
            CMD_RESET: begin
              clear       = 1'b1;
              ref_len_nxt = '0;
              qlen_nxt    = '0;
              cur_nxt     = '0;
            end
            CMD_REF: begin
              // reference is closed once the query has begun
              if (qlen_r != '0 || ref_len_r >= LW'(MAX_LEN)) begin
                err_nxt = 1'b1;
              end else begin
                ref_wr      = 1'b1;
                ref_len_nxt = ref_len_r + LW'(1);
                cur_nxt     = ref_len_r + LW'(1);
              end
            end
            CMD_QUERY: begin
              if (qlen_r >= LW'(MAX_LEN)) begin
                err_nxt = 1'b1;
              end else begin
                qlen_nxt = qlen_r + LW'(1);
                if (ref_len_r == '0) begin
                  // empty reference: distance is the query length
                  cur_nxt = qlen_r + LW'(1);
                end else begin
                  wave_start  = 1'b1;
                  out_vld_nxt = 1'b0;
                  state_nxt   = ST_BUSY;
                end
              end
            end
            default: begin
              err_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_BUSY: begin
        if (wave_done) begin
          cur_nxt     = wave_dist;
          out_vld_nxt = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      ref_len_r <= '0;
      qlen_r    <= '0;
      cur_r     <= '0;
      out_vld_r <= 1'b0;
      err_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      ref_len_r <= ref_len_nxt;
      qlen_r    <= qlen_nxt;
      cur_r     <= cur_nxt;
      out_vld_r <= out_vld_nxt;
      err_r     <= err_nxt;
    end
  end

  // first cell sees column entry 0: old value is the query length, new one is length + 1
  assign wv_vld[0]  = wave_start;
  assign wv_sym[0]  = in_symbol;
  assign wv_diag[0] = qlen_r;
  assign wv_left[0] = qlen_r + LW'(1);

  for (genvar j = 0; j < MAX_LEN; j++) begin : g_cell
    eded_cell #(
      .IDX (j),
      .LW  (LW)
    ) u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .clear         (clear),
      .wr_en         (ref_wr),
      .wr_sym        (in_symbol),
      .ref_len       (ref_len_r),
      .wave_in_vld   (wv_vld[j]),
      .wave_in_sym   (wv_sym[j]),
      .wave_in_diag  (wv_diag[j]),
      .wave_in_left  (wv_left[j]),
      .wave_out_vld  (wv_vld[j+1]),
      .wave_out_sym  (wv_sym[j+1]),
      .wave_out_diag (wv_diag[j+1]),
      .wave_out_left (wv_left[j+1])
    );
  end

  // distance saturates at the top of the output field
  assign cur_ext      = {DIST_W'(0), cur_r};
  assign out_distance = (cur_ext > (DIST_W+LW)'(DIST_MAX)) ? DIST_W'(DIST_MAX)
                                                           : cur_ext[DIST_W-1:0];
  assign out_valid    = out_vld_r;
  assign out_error    = err_r;

endmodule

// ===== src/eded_cell.sv =====
// one column cell: holds a reference symbol and one distance column entry
// depends on eded_pkg; instantiated in a row by edit_distance_engine_core

module eded_cell import eded_pkg::*; #(
  parameter int IDX = 0,
  parameter int LW  = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             clear,
  input  logic             wr_en,
  input  logic [SYM_W-1:0] wr_sym,
  input  logic [LW-1:0]    ref_len,
  input  logic             wave_in_vld,
  input  logic [SYM_W-1:0] wave_in_sym,
  input  logic [LW-1:0]    wave_in_diag,
  input  logic [LW-1:0]    wave_in_left,
  output logic             wave_out_vld,
  output logic [SYM_W-1:0] wave_out_sym,
  output logic [LW-1:0]    wave_out_diag,
  output logic [LW-1:0]    wave_out_left
);

  logic [SYM_W-1:0] sym_r;
  logic [LW-1:0]    d_r;
  logic             vld_r;
  logic [SYM_W-1:0] osym_r;
  logic [LW-1:0]    odiag_r;
  logic [LW-1:0]    oleft_r;
  logic             active;
  logic [LW-1:0]    up_p1;
  logic [LW-1:0]    left_p1;
  logic [LW-1:0]    diag_c;
  logic [LW-1:0]    m1;
  logic [LW-1:0]    d_nxt;

  assign active  = LW'(IDX) < ref_len;
  assign up_p1   = d_r + LW'(1);
  assign left_p1 = wave_in_left + LW'(1);
  assign diag_c  = wave_in_diag + LW'(sym_r != wave_in_sym);
  assign m1      = (up_p1 < left_p1) ? up_p1 : left_p1;
  assign d_nxt   = (m1 < diag_c) ? m1 : diag_c;

  // reference symbol store, written once per append
  always_ff @(posedge clk) begin
    if (wr_en && ref_len == LW'(IDX)) begin
      sym_r <= wr_sym;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      d_r   <= LW'(IDX + 1);
      vld_r <= 1'b0;
    end else begin
      vld_r <= wave_in_vld && active;
      if (wave_in_vld && active) begin
        d_r <= d_nxt;
      end
    end
  end

  // wave payload handed to the right neighbor
  always_ff @(posedge clk) begin
    if (wave_in_vld && active) begin
      osym_r  <= wave_in_sym;
      odiag_r <= d_r;
      oleft_r <= d_nxt;
    end
  end

  assign wave_out_vld  = vld_r;
  assign wave_out_sym  = osym_r;
  assign wave_out_diag = odiag_r;
  assign wave_out_left = oleft_r;

endmodule

// ===== src/eded_checker.sv =====
// port-level checks for the edit distance engine, bound to the top level
// depends on eded_pkg and edit_distance_engine_core

module eded_checker import eded_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic [CMD_W-1:0]  in_command,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DIST_W-1:0] out_distance,
  input logic              out_error
);

  // a pending word holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_distance) && $stable(out_error))
    else $error("result word changed while stalled");

  // no new word while an untaken result sits in the output slot
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while result stalled");

  // emptying both strings reports distance zero without error
  a_reset_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_command == CMD_RESET
      |=> out_valid && out_distance == '0 && !out_error)
    else $error("reset word result wrong");

  // the unused command code is always flagged
  a_bad_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_command != CMD_RESET && in_command != CMD_REF
      && in_command != CMD_QUERY |=> out_valid && out_error)
    else $error("unused command not flagged");

endmodule

bind edit_distance_engine_core eded_checker u_eded_checker (.*);
